// ===== rtl/bbox_frustum_cull_assert.svh =====
// assertion macros shared by the frustum cull rtl
`ifndef BBOX_FRUSTUM_CULL_ASSERT_SVH
`define BBOX_FRUSTUM_CULL_ASSERT_SVH
// property a implies b at the same edge
`define BFC_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("bfc check failed");
// property a implies b at the next edge
`define BFC_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("bfc check failed");
`endif

// ===== rtl/bfc_pkg.sv =====
// shared types and constants for the frustum cull block
`timescale 1ns / 1ps
package bfc_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned QDepth   = 2;
  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;
  localparam logic signed [31:0] QOne = 32'sh1 <<< FracBits;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               last;
  } vtx_t;

  typedef struct packed {
    logic signed [59:0] t0;
    logic signed [59:0] t1;
    logic signed [59:0] t2;
    logic signed [59:0] t3;
    logic               last;
  } xform_t;
endpackage

// ===== rtl/bfc_front.sv =====
// front end: matrix transform of one vertex, one product per cycle
`timescale 1ns / 1ps
`include "bbox_frustum_cull_assert.svh"
module bfc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bfc_pkg::vtx_t       in_vtx_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bfc_pkg::xform_t     out_xf_o
);
  typedef enum logic [1:0] {F_IDLE, F_MUL, F_OUT} fstate_e;
  fstate_e state_q;
  logic [63:0] regs_q [bfc_pkg::NumRegs];
  bfc_pkg::vtx_t vtx_q;
  logic [3:0] step_q;
  logic signed [59:0] acc_q [4];
  logic signed [31:0] v_sel, m_sel;
  logic signed [63:0] prod;
  logic signed [59:0] prod_fl;
  logic [1:0] r_sel, c_sel;
  logic [63:0] reg_sel;

  assign r_sel = step_q[3:2];
  assign c_sel = step_q[1:0];
  always_comb begin
    unique case (r_sel)
      2'd0: v_sel = vtx_q.x;
      2'd1: v_sel = vtx_q.y;
      2'd2: v_sel = vtx_q.z;
      default: v_sel = vtx_q.w;
    endcase
    reg_sel = regs_q[{r_sel, c_sel[1]}];
    m_sel = c_sel[0] ? reg_sel[63:32] : reg_sel[31:0];
  end
  assign prod = v_sel * m_sel;
  assign prod_fl = 60'(prod >>> bfc_pkg::FracBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= 64'(bfc_pkg::QOne);
      regs_q[1] <= '0;
      regs_q[2] <= {bfc_pkg::QOne, 32'd0};
      regs_q[3] <= '0;
      regs_q[4] <= '0;
      regs_q[5] <= 64'(bfc_pkg::QOne);
      regs_q[6] <= '0;
      regs_q[7] <= {bfc_pkg::QOne, 32'd0};
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: if (in_valid_i) begin
          vtx_q   <= in_vtx_i;
          step_q  <= '0;
          for (int i = 0; i < 4; i++) acc_q[i] <= '0;
          state_q <= F_MUL;
        end
        F_MUL: begin
          acc_q[c_sel] <= acc_q[c_sel] + prod_fl;
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) state_q <= F_OUT;
        end
        F_OUT: if (out_ready_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == F_IDLE);
  assign out_valid_o = (state_q == F_OUT);
  assign out_xf_o = '{t0: acc_q[0], t1: acc_q[1], t2: acc_q[2], t3: acc_q[3],
                      last: vtx_q.last};

  `BFC_ASSERT_NXT(a_take_mul, in_valid_i && in_ready_o, state_q == F_MUL)
  `BFC_ASSERT_IMP(a_out_excl, out_valid_o, !in_ready_o)
  `BFC_ASSERT_NXT(a_hold, out_valid_o && !out_ready_i, out_valid_o)
endmodule

// ===== rtl/bfc_fifo.sv =====
// two entry queue between transform and divide
`timescale 1ns / 1ps
`include "bbox_frustum_cull_assert.svh"
module bfc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bfc_pkg::xform_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bfc_pkg::xform_t  out_data_o
);
  bfc_pkg::xform_t mem_q [bfc_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  assign in_ready_o  = (cnt_q != 2'(bfc_pkg::QDepth));
  assign out_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rp_q];
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
  `BFC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 2'(bfc_pkg::QDepth))
  `BFC_ASSERT_NXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
  `BFC_ASSERT_NXT(a_cnt_dn, pop && !push, cnt_q == $past(cnt_q) - 2'd1)
endmodule

// ===== rtl/bfc_back.sv =====
// back end: three restoring divides, running extremes and verdict
`timescale 1ns / 1ps
`include "bbox_frustum_cull_assert.svh"
module bfc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bfc_pkg::xform_t  in_xf_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             visible_o,
  output logic             sat_o
);
  typedef enum logic [2:0] {B_IDLE, B_SETUP, B_DIV, B_UPD, B_OUT} bstate_e;
  bstate_e state_q;
  bfc_pkg::xform_t xf_q;
  logic [1:0] ax_q;
  logic [6:0] cnt_q;
  logic [58:0] nt_q, nw_q;
  logic [59:0] rem_q;
  logic [74:0] quo_q;
  logic neg_q, zero_w_q;
  logic signed [31:0] mn_q [3];
  logic signed [31:0] mx_q [3];
  logic sat_q, vis_q, osat_q;
  logic signed [59:0] t_sel;
  logic [59:0] rem_sh, rem_sub;
  logic signed [31:0] q;
  logic q_sat;
  logic vis_c;
  localparam int unsigned Iters = 59 + bfc_pkg::FracBits;
  localparam logic [74:0] IntLim = 75'(1) << (32 - bfc_pkg::FracBits);

  always_comb begin
    unique case (ax_q)
      2'd0: t_sel = xf_q.t0;
      2'd1: t_sel = xf_q.t1;
      default: t_sel = xf_q.t2;
    endcase
  end
  // numerator t<<frac fed one bit per step, msb first
  assign rem_sh = {rem_q[58:0],
                   (cnt_q < 7'd59) ? nt_q[6'(7'd58 - cnt_q)] : 1'b0};
  assign rem_sub = rem_sh - {1'b0, nw_q};

  always_comb begin
    q_sat = 1'b0;
    q = '0;
    if (zero_w_q) begin
      q_sat = 1'b1;
      q = (t_sel > 0) ? bfc_pkg::QMax : ((t_sel < 0) ? bfc_pkg::QMin : '0);
    end else if ((quo_q >> bfc_pkg::FracBits) >= IntLim) begin
      q_sat = 1'b1;
      q = neg_q ? bfc_pkg::QMin : bfc_pkg::QMax;
    end else if (neg_q) begin
      if (quo_q > 75'h80000000) begin
        q_sat = 1'b1; q = bfc_pkg::QMin;
      end else q = 32'(-quo_q);
    end else if (quo_q > 75'h7fffffff) begin
      q_sat = 1'b1; q = bfc_pkg::QMax;
    end else q = quo_q[31:0];
  end

  always_comb begin
    vis_c = 1'b1;
    for (int i = 0; i < 3; i++)
      if (mn_q[i] > bfc_pkg::QOne || mx_q[i] < -bfc_pkg::QOne) vis_c = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ax_q <= '0; cnt_q <= '0; sat_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mn_q[i] <= bfc_pkg::QMax; mx_q[i] <= bfc_pkg::QMin;
      end
      vis_q <= 1'b0; osat_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: if (in_valid_i && in_ready_o) begin
          xf_q <= in_xf_i; ax_q <= '0; state_q <= B_SETUP;
        end
        B_SETUP: begin
          nt_q <= t_sel[59] ? 59'(-t_sel) : t_sel[58:0];
          nw_q <= xf_q.t3[59] ? 59'(-xf_q.t3) : xf_q.t3[58:0];
          neg_q <= t_sel[59] ^ xf_q.t3[59];
          zero_w_q <= (xf_q.t3 == '0);
          rem_q <= '0; quo_q <= '0; cnt_q <= '0;
          state_q <= (xf_q.t3 == '0) ? B_UPD : B_DIV;
        end
        B_DIV: begin
          if (!rem_sub[59]) begin
            rem_q <= rem_sub; quo_q <= {quo_q[73:0], 1'b1};
          end else begin
            rem_q <= rem_sh; quo_q <= {quo_q[73:0], 1'b0};
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(Iters - 1)) state_q <= B_UPD;
        end
        B_UPD: begin
          if (q < mn_q[ax_q]) mn_q[ax_q] <= q;
          if (q > mx_q[ax_q]) mx_q[ax_q] <= q;
          if (q_sat) sat_q <= 1'b1;
          if (ax_q == 2'd2) state_q <= xf_q.last ? B_OUT : B_IDLE;
          else begin
            ax_q <= ax_q + 2'd1; state_q <= B_SETUP;
          end
        end
        B_OUT: begin
          vis_q <= vis_c; osat_q <= sat_q;
          for (int i = 0; i < 3; i++) begin
            mn_q[i] <= bfc_pkg::QMax; mx_q[i] <= bfc_pkg::QMin;
          end
          sat_q <= 1'b0;
          state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // result register decoupled from the divider
  logic ovalid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (state_q == B_OUT) ovalid_q <= 1'b1;
    else if (out_ready_i) ovalid_q <= 1'b0;
  end
  assign in_ready_o  = (state_q == B_IDLE) && !(ovalid_q && !out_ready_i);
  assign out_valid_o = ovalid_q;
  assign visible_o   = vis_q;
  assign sat_o       = osat_q;

  `BFC_ASSERT_NXT(a_out_set, state_q == B_OUT, out_valid_o)
  `BFC_ASSERT_IMP(a_zero_nodiv, state_q == B_DIV, !zero_w_q)
  `BFC_ASSERT_NXT(a_clear, state_q == B_OUT, !sat_q)
endmodule

// ===== rtl/bbox_frustum_cull.sv =====
// top level of the bounding box frustum cull block
`timescale 1ns / 1ps
// bounding box frustum cull: each word on s_axis is one box corner (x,y,z,w
// in signed q16.16, tlast marks the final corner). the front end multiplies
// the vertex by the configured 4x4 matrix with one 32x32 multiplier: it loads
// the vertex, forms each matrix product in turn, then hands off the result. a
// two entry queue hands the transformed vertex to the back end, which runs a
// restoring divider one quotient bit per cycle, 75 steps per axis, three axes
// per vertex, skipping the divide when w is zero; the divider sets the
// sustained rate. on the last corner one word appears on m_axis: tdata[0]
// visible, tdata[1] a divide of this box saturated. the matrix resets to
// identity; write it only while idle.
module bbox_frustum_cull (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // vertex_x, vertex_y, vertex_z, vertex_w
  input  logic         s_axis_tlast,   // last_vertex
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata    // visible, divide_saturated, zero fill
);
  bfc_pkg::vtx_t   vtx;
  bfc_pkg::xform_t f_xf, q_xf;
  logic f_valid, f_ready, q_valid, q_ready;
  logic vis, sat;

  assign vtx = '{x: s_axis_tdata[31:0], y: s_axis_tdata[63:32],
                 z: s_axis_tdata[95:64], w: s_axis_tdata[127:96],
                 last: s_axis_tlast};

  bfc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_vtx_i(vtx),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_xf_o(f_xf)
  );
  bfc_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_xf),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_xf)
  );
  bfc_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_xf_i(q_xf),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .visible_o(vis), .sat_o(sat)
  );
  assign m_axis_tdata = {6'd0, sat, vis};
endmodule
